>>> src/padsr_pkg.sv
// Package: shared types and constants for the polyphonic ADSR envelope core.
`default_nettype none
package padsr_pkg;

    localparam int VOICES  = 8;
    localparam int VOICE_W = 3;
    localparam int LEVEL_W = 16;
    localparam int CFG_W   = 7;

    localparam logic [LEVEL_W-1:0] PEAK_LEVEL = 16'hFF00;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [1:0] REG_ATTACK  = 2'd0;
    localparam logic [1:0] REG_DECAY   = 2'd1;
    localparam logic [1:0] REG_SUSTAIN = 2'd2;
    localparam logic [1:0] REG_RELEASE = 2'd3;

    localparam logic [CFG_W-1:0] ATTACK_RST  = 7'd0;
    localparam logic [CFG_W-1:0] DECAY_RST   = 7'd64;
    localparam logic [CFG_W-1:0] SUSTAIN_RST = 7'd100;
    localparam logic [CFG_W-1:0] RELEASE_RST = 7'd64;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } phase_t;

    typedef struct packed {
        logic [CFG_W-1:0] attack_time;
        logic [CFG_W-1:0] decay_time;
        logic [CFG_W-1:0] sustain_level;
        logic [CFG_W-1:0] release_time;
    } cfg_t;

    typedef struct packed {
        logic               op;
        logic [VOICE_W-1:0] voice;
        logic               retrigger;
        logic               gate_active;
    } item_t;

    typedef struct packed {
        logic               wr_en;
        phase_t             phase;
        logic [LEVEL_W-1:0] level;
    } voice_upd_t;

endpackage
`default_nettype wire

>>> src/padsr_cfg_regs.sv
// APB-style register bank holding the four envelope settings.
`default_nettype none
module padsr_cfg_regs (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [3:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready,
    output padsr_pkg::cfg_t          cfg
);

    padsr_pkg::cfg_t cfg_reg;
    logic            wr_en;
    logic [1:0]      reg_idx;
    logic [padsr_pkg::CFG_W-1:0] rd_val;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.attack_time   <= padsr_pkg::ATTACK_RST;
            cfg_reg.decay_time    <= padsr_pkg::DECAY_RST;
            cfg_reg.sustain_level <= padsr_pkg::SUSTAIN_RST;
            cfg_reg.release_time  <= padsr_pkg::RELEASE_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                padsr_pkg::REG_ATTACK:  cfg_reg.attack_time   <= pwdata[6:0];
                padsr_pkg::REG_DECAY:   cfg_reg.decay_time    <= pwdata[6:0];
                padsr_pkg::REG_SUSTAIN: cfg_reg.sustain_level <= pwdata[6:0];
                padsr_pkg::REG_RELEASE: cfg_reg.release_time  <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            padsr_pkg::REG_ATTACK:  rd_val = cfg_reg.attack_time;
            padsr_pkg::REG_DECAY:   rd_val = cfg_reg.decay_time;
            padsr_pkg::REG_SUSTAIN: rd_val = cfg_reg.sustain_level;
            padsr_pkg::REG_RELEASE: rd_val = cfg_reg.release_time;
            default:                rd_val = '0;
        endcase
    end

    assign prdata = {25'd0, rd_val};
    assign cfg    = cfg_reg;

endmodule
`default_nettype wire

>>> src/padsr_voice_store.sv
// Per-voice phase and level registers, one read and one write port.
`default_nettype none
module padsr_voice_store (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic [padsr_pkg::VOICE_W-1:0]       rd_voice,
    output padsr_pkg::phase_t                        rd_phase,
    output logic      [padsr_pkg::LEVEL_W-1:0]       rd_level,
    input  wire logic [padsr_pkg::VOICE_W-1:0]       wr_voice,
    input  wire padsr_pkg::voice_upd_t               upd
);

    padsr_pkg::phase_t                  phase_reg [padsr_pkg::VOICES];
    logic [padsr_pkg::LEVEL_W-1:0]      level_reg [padsr_pkg::VOICES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < padsr_pkg::VOICES; i++)
            begin
                phase_reg[i] <= padsr_pkg::PH_IDLE;
                level_reg[i] <= '0;
            end
        end
        else if (upd.wr_en)
        begin
            phase_reg[wr_voice] <= upd.phase;
            level_reg[wr_voice] <= upd.level;
        end
    end

    assign rd_phase = phase_reg[rd_voice];
    assign rd_level = level_reg[rd_voice];

endmodule
`default_nettype wire

>>> src/padsr_voice_step.sv
// One envelope update for one voice: retrigger, gate restart, phase step; a release word moves it to release.
`default_nettype none
module padsr_voice_step (
    input  wire logic                           item_valid,
    input  wire padsr_pkg::item_t               item,
    input  wire padsr_pkg::cfg_t                cfg,
    input  wire padsr_pkg::phase_t              cur_phase,
    input  wire logic [padsr_pkg::LEVEL_W-1:0]  cur_level,
    output padsr_pkg::voice_upd_t               upd,
    output logic                                res_valid,
    output logic      [7:0]                     res_level,
    output padsr_pkg::phase_t                   res_phase
);

    logic                               in_range;
    logic [padsr_pkg::LEVEL_W-1:0]      lvl_pre;
    padsr_pkg::phase_t                  ph_pre;
    logic [padsr_pkg::LEVEL_W-1:0]      lvl_new;
    padsr_pkg::phase_t                  ph_new;
    logic [3:0]                         atk_sh;
    logic [3:0]                         dec_sh;
    logic [3:0]                         rel_sh;
    logic [padsr_pkg::LEVEL_W:0]        atk_sum;
    logic [padsr_pkg::LEVEL_W-1:0]      dec_raw;
    logic [padsr_pkg::LEVEL_W-1:0]      rel_raw;
    logic [padsr_pkg::LEVEL_W-1:0]      dec_step;
    logic [padsr_pkg::LEVEL_W-1:0]      rel_step;
    logic [padsr_pkg::LEVEL_W-1:0]      dec_lvl;
    logic [padsr_pkg::LEVEL_W-1:0]      target;

    assign in_range = ({1'b0, item.voice} < (padsr_pkg::VOICE_W+1)'(padsr_pkg::VOICES));

    // retrigger first, then gate restart from zero
    always_comb
    begin
        lvl_pre = cur_level;
        ph_pre  = cur_phase;
        if (item.retrigger)
        begin
            lvl_pre = 16'd1;
            ph_pre  = padsr_pkg::PH_ATTACK;
        end
        if (lvl_pre == '0 && item.gate_active)
        begin
            lvl_pre = 16'd1;
            ph_pre  = padsr_pkg::PH_ATTACK;
        end
    end

    assign atk_sh = 4'd3 + {2'b00, cfg.attack_time[6:5]};
    assign dec_sh = 4'd3 + {1'b0, cfg.decay_time[6:4]};
    assign rel_sh = 4'd3 + {1'b0, cfg.release_time[6:4]};

    // sustain value = level * 510 = level*512 - level*2
    assign target = {cfg.sustain_level, 9'd0} - {8'd0, cfg.sustain_level, 1'b0};

    assign atk_sum  = {1'b0, lvl_pre} + {1'b0, padsr_pkg::PEAK_LEVEL >> atk_sh};
    assign dec_raw  = lvl_pre >> dec_sh;
    assign rel_raw  = lvl_pre >> rel_sh;
    assign dec_step = (dec_raw == '0) ? 16'd1 : dec_raw;
    assign rel_step = (rel_raw == '0) ? 16'd1 : rel_raw;
    assign dec_lvl  = lvl_pre - dec_step;

    always_comb
    begin
        lvl_new = lvl_pre;
        ph_new  = ph_pre;
        case (ph_pre)
            padsr_pkg::PH_ATTACK:
            begin
                if (atk_sum >= {1'b0, padsr_pkg::PEAK_LEVEL})
                begin
                    lvl_new = padsr_pkg::PEAK_LEVEL;
                    ph_new  = padsr_pkg::PH_DECAY;
                end
                else
                begin
                    lvl_new = atk_sum[padsr_pkg::LEVEL_W-1:0];
                end
            end
            padsr_pkg::PH_DECAY:
            begin
                if (lvl_pre > target)
                begin
                    if (dec_lvl <= target)
                    begin
                        lvl_new = target;
                        ph_new  = padsr_pkg::PH_SUSTAIN;
                    end
                    else
                    begin
                        lvl_new = dec_lvl;
                    end
                end
                else
                begin
                    ph_new = padsr_pkg::PH_SUSTAIN;
                end
            end
            padsr_pkg::PH_SUSTAIN:
            begin
                lvl_new = target;
            end
            padsr_pkg::PH_RELEASE:
            begin
                if (rel_step >= lvl_pre)
                begin
                    lvl_new = '0;
                    ph_new  = padsr_pkg::PH_IDLE;
                end
                else
                begin
                    lvl_new = lvl_pre - rel_step;
                end
            end
            default:
            begin
                lvl_new = '0;
                ph_new  = padsr_pkg::PH_IDLE;
            end
        endcase
    end

    always_comb
    begin
        upd.wr_en = item_valid & in_range;
        if (item.op == padsr_pkg::OP_RELEASE)
        begin
            upd.phase = padsr_pkg::PH_RELEASE;
            upd.level = cur_level;
        end
        else
        begin
            upd.phase = ph_new;
            upd.level = lvl_new;
        end
    end

    assign res_valid = item_valid & (item.op == padsr_pkg::OP_TICK);
    assign res_level = in_range ? lvl_new[15:8] : 8'd0;
    assign res_phase = in_range ? ph_new : padsr_pkg::PH_IDLE;

endmodule
`default_nettype wire

>>> src/polyphonic_adsr_envelope_core.sv
// Top level: polyphonic ADSR envelope core with APB settings port.
// Path: input register, then result register, before a tick's result shows with done high.
// Throughput: one word per cycle; busy is never raised, ticks and release words mix freely.
// Timing: the input register feeds one voice-state read, one shift/add/compare step and the
//   write-back, so a word for the same voice in the next cycle sees the updated state.
// Reset: all voices idle at level zero, settings at attack 0, decay 64, sustain 100,
//   release 64; done low. The receiver cannot stall, so each result shows for one cycle.
`default_nettype none
module polyphonic_adsr_envelope_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // APB settings port
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [3:0]                       paddr,
    input  wire logic [31:0]                      pwdata,
    output logic      [31:0]                      prdata,
    output logic                                  pready,
    // command side
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic                             op,
    input  wire logic [padsr_pkg::VOICE_W-1:0]    voice,
    input  wire logic                             retrigger,
    input  wire logic                             gate_active,
    // result side
    output logic                                  done,
    output logic      [padsr_pkg::VOICE_W-1:0]    voice_out,
    output logic      [7:0]                       level,
    output logic      [2:0]                       phase_out
);

    padsr_pkg::cfg_t        cfg;

    // input register: the accepted word
    logic                   item_valid_reg;
    padsr_pkg::item_t       item_reg;

    // stored state of the addressed voice
    padsr_pkg::phase_t              cur_phase;
    logic [padsr_pkg::LEVEL_W-1:0]  cur_level;

    // step results
    padsr_pkg::voice_upd_t  upd;
    logic                   res_valid;
    logic [7:0]             res_level;
    padsr_pkg::phase_t      res_phase;

    // result register
    logic                           done_reg;
    logic [padsr_pkg::VOICE_W-1:0]  voice_out_reg;
    logic [7:0]                     level_reg;
    padsr_pkg::phase_t              phase_out_reg;

    logic                   accept;

    // never stalls: each word is stepped combinationally between the input and result registers
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    padsr_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= accept;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.op          <= op;
            item_reg.voice       <= voice;
            item_reg.retrigger   <= retrigger;
            item_reg.gate_active <= gate_active;
        end
    end

    // state read and written back at the same voice in the compute cycle
    padsr_voice_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_voice (item_reg.voice),
        .rd_phase (cur_phase),
        .rd_level (cur_level),
        .wr_voice (item_reg.voice),
        .upd      (upd)
    );

    padsr_voice_step u_step (
        .item_valid (item_valid_reg),
        .item       (item_reg),
        .cfg        (cfg),
        .cur_phase  (cur_phase),
        .cur_level  (cur_level),
        .upd        (upd),
        .res_valid  (res_valid),
        .res_level  (res_level),
        .res_phase  (res_phase)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            voice_out_reg <= item_reg.voice;
            level_reg     <= res_level;
            phase_out_reg <= res_phase;
        end
    end

    assign done      = done_reg;
    assign voice_out = voice_out_reg;
    assign level     = level_reg;
    assign phase_out = phase_out_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // a result word only follows a tick word in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(item_valid_reg && item_reg.op == padsr_pkg::OP_TICK))
        else $error("done without a preceding tick word");

    // an accepted word reaches the compute stage in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> item_valid_reg)
        else $error("accepted word lost before compute stage");

    // idle is only ever reported at level zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && phase_out == padsr_pkg::PH_IDLE) |-> (level == 8'd0))
        else $error("idle voice reported nonzero level");

    // attack stays below the peak, so the top byte never saturates there
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && phase_out == padsr_pkg::PH_ATTACK) |-> (level != 8'hFF))
        else $error("attack level reached peak without moving to decay");

endmodule
`default_nettype wire

>>> bench/polyphonic_adsr_envelope_core_tb.sv
`timescale 1ns / 100ps
// Testbench: per-voice ADSR envelope core checked against an in-bench envelope predictor.
module polyphonic_adsr_envelope_core_tb;
    import padsr_pkg::*;

    // The core registers each tick's result after the input register; release words give none,
    // so a settings write waits for the last expected level, then waits out DRAIN_CYCLES.
    localparam int DRAIN_CYCLES    = 8;
    localparam int RANDOM_PHASES   = 8;
    localparam int WORDS_PER_PHASE = 85;
    localparam int MAX_REPORTS     = 10;
    localparam int TIMEOUT_NS      = 2_000_000;

    typedef struct packed {
        logic [VOICE_W-1:0] voice;
        logic [7:0]         level;
        phase_t             phase;
    } env_result_t;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [3:0]          paddr       = '0;
    logic [31:0]         pwdata      = '0;
    logic [31:0]         prdata;
    logic                pready;
    logic                start       = 1'b0;
    logic                busy;
    logic                op          = OP_TICK;
    logic [VOICE_W-1:0]  voice       = '0;
    logic                retrigger   = 1'b0;
    logic                gate_active = 1'b0;
    logic                done;
    logic [VOICE_W-1:0]  voice_out;
    logic [7:0]          level;
    logic [2:0]          phase_out;

    // Predicted voice state and settings shadow.
    phase_t              phase_mem [VOICES];
    logic [LEVEL_W-1:0]  level_mem [VOICES];
    logic [CFG_W-1:0]    attack_cfg;
    logic [CFG_W-1:0]    decay_cfg;
    logic [CFG_W-1:0]    sustain_cfg;
    logic [CFG_W-1:0]    release_cfg;

    env_result_t         expected_levels [$];
    int                  fail_count = 0;
    int                  idle_pct   = 0;
    logic                note_held [VOICES];

    polyphonic_adsr_envelope_core i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .voice       (voice),
        .retrigger   (retrigger),
        .gate_active (gate_active),
        .done        (done),
        .voice_out   (voice_out),
        .level       (level),
        .phase_out   (phase_out)
    );

    always #5 clk = ~clk;

    function automatic void report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("mismatch @%0t: %s", $time, msg);
    endfunction

    // Exponential fall: level >> (3 + setting/16), never below one.
    function automatic int unsigned fall_step(input int unsigned lvl,
                                              input logic [CFG_W-1:0] setting);
        int unsigned st;
        st = lvl >> (3 + (setting >> 4));
        return (st < 1) ? 1 : st;
    endfunction

    // Advance the predicted state for one accepted word; a tick queues its level.
    function automatic void predict_envelope(input logic o, input logic [VOICE_W-1:0] v,
                                             input logic rt, input logic g);
        int unsigned lvl;
        int unsigned tgt;
        int unsigned st;
        phase_t      ph;
        env_result_t res;
        if (o == OP_RELEASE) begin
            phase_mem[v] = PH_RELEASE;
            return;
        end
        lvl = 32'(level_mem[v]);
        ph  = phase_mem[v];
        // retrigger first, then the gate restart from zero
        if (rt) begin
            lvl = 1;
            ph  = PH_ATTACK;
        end
        if (lvl == 0 && g) begin
            lvl = 1;
            ph  = PH_ATTACK;
        end
        tgt = sustain_cfg * 510;
        case (ph)
            PH_ATTACK:
            begin
                lvl = lvl + (32'(PEAK_LEVEL) >> (3 + (attack_cfg >> 5)));
                if (lvl >= 32'(PEAK_LEVEL)) begin
                    lvl = 32'(PEAK_LEVEL);
                    ph  = PH_DECAY;
                end
            end
            PH_DECAY:
            begin
                if (lvl > tgt) begin
                    lvl = lvl - fall_step(lvl, decay_cfg);
                    if (lvl <= tgt) begin
                        lvl = tgt;
                        ph  = PH_SUSTAIN;
                    end
                end else begin
                    // already at or under the target: hold the level
                    ph = PH_SUSTAIN;
                end
            end
            PH_SUSTAIN:
            begin
                lvl = tgt;
            end
            PH_RELEASE:
            begin
                st = fall_step(lvl, release_cfg);
                if (st >= lvl) begin
                    lvl = 0;
                    ph  = PH_IDLE;
                end else begin
                    lvl = lvl - st;
                end
            end
            default:
            begin
                lvl = 0;
                ph  = PH_IDLE;
            end
        endcase
        level_mem[v] = LEVEL_W'(lvl);
        phase_mem[v] = ph;
        res.voice = v;
        res.level = 8'(lvl >> 8);
        res.phase = ph;
        expected_levels.push_back(res);
    endfunction

    // Monitor: sample at the rising edge, check the result first, then predict the word.
    always @(posedge clk) begin
        env_result_t exp_res;
        if (rst_n) begin
            if (done) begin
                if (expected_levels.size() == 0) begin
                    report_mismatch($sformatf("unexpected level voice=%0d level=%0d phase=%0d",
                                              voice_out, level, phase_out));
                end else begin
                    exp_res = expected_levels.pop_front();
                    if (voice_out !== exp_res.voice || level !== exp_res.level ||
                        phase_out !== exp_res.phase)
                        report_mismatch($sformatf(
                            "exp voice=%0d level=%0d phase=%0d, got voice=%0d level=%0d phase=%0d",
                            exp_res.voice, exp_res.level, exp_res.phase,
                            voice_out, level, phase_out));
                end
            end
            if (start && !busy)
                predict_envelope(op, voice, retrigger, gate_active);
        end
    end

    // Send one word; called and returning at a falling edge.
    task automatic send_word(input logic o, input logic [VOICE_W-1:0] v,
                             input logic rt, input logic g);
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(negedge clk);
        end
        start       <= 1'b1;
        op          <= o;
        voice       <= v;
        retrigger   <= rt;
        gate_active <= g;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Write one setting while the core is quiet, then read it back.
    task automatic set_register(input logic [1:0] idx, input logic [CFG_W-1:0] val);
        logic [31:0] data;
        data        = $urandom;
        data[6:0]   = val;
        start <= 1'b0;
        while (expected_levels.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        // write: setup then access; upper data bits are junk and must be dropped
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        case (idx)
            REG_ATTACK:  attack_cfg  = val;
            REG_DECAY:   decay_cfg   = val;
            REG_SUSTAIN: sustain_cfg = val;
            default:     release_cfg = val;
        endcase
        // back-to-back read of the same register
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== 32'(val))
            report_mismatch($sformatf("reg %0d readback exp=%0d got=%0h", idx, val, prdata));
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Ticks on idle voices keep them idle at level zero.
    task automatic test_idle_voice();
        send_word(OP_TICK, 3'd5, 1'b0, 1'b0);
        send_word(OP_TICK, 3'd7, 1'b0, 1'b0);
    endtask

    // Release on an idle voice at zero: next tick goes straight back to idle.
    task automatic test_release_when_idle();
        send_word(OP_RELEASE, 3'd6, 1'b1, 1'b1);
        send_word(OP_TICK, 3'd6, 1'b0, 1'b0);
        send_word(OP_RELEASE, 3'd0, 1'b0, 1'b0);
        send_word(OP_TICK, 3'd0, 1'b0, 1'b0);
    endtask

    // Gate restart from zero, linear climb, clamp at the peak into decay.
    task automatic test_attack_to_peak();
        set_register(REG_ATTACK, 7'd0);
        set_register(REG_DECAY, 7'd0);
        set_register(REG_SUSTAIN, 7'd0);
        repeat (8) send_word(OP_TICK, 3'd2, 1'b0, 1'b1);
    endtask

    // One decay step, then raise sustain above the level: moves to sustain unchanged.
    task automatic test_decay_and_sustain();
        send_word(OP_TICK, 3'd2, 1'b0, 1'b1);
        set_register(REG_SUSTAIN, 7'd127);
        send_word(OP_TICK, 3'd2, 1'b0, 1'b1);
        send_word(OP_TICK, 3'd2, 1'b0, 1'b1);
    endtask

    // Release from sustain, retrigger mid-release, gate held during release,
    // retrigger on an idle voice without gate.
    task automatic test_release_and_retrigger();
        send_word(OP_RELEASE, 3'd2, 1'b0, 1'b0);
        send_word(OP_TICK, 3'd2, 1'b0, 1'b0);
        send_word(OP_TICK, 3'd2, 1'b1, 1'b1);
        send_word(OP_RELEASE, 3'd2, 1'b1, 1'b0);
        send_word(OP_TICK, 3'd2, 1'b0, 1'b1);
        send_word(OP_TICK, 3'd7, 1'b1, 1'b0);
        send_word(OP_TICK, 3'd7, 1'b0, 1'b1);
    endtask

    // Note-on / hold / note-off sequences over one to eight voices, with some noise words.
    task automatic test_random_traffic(input int ph);
        cfg_t                plan;
        int                  nv;
        int                  r;
        logic [VOICE_W-1:0]  base;
        logic [VOICE_W-1:0]  v;
        case (ph % 4)
            1:       idle_pct = 69;
            3:       idle_pct = 32;
            default: idle_pct = 0;
        endcase
        // {attack, decay, sustain, release}
        case (ph)
            0:       begin plan = {7'd0, 7'd0, 7'd0, 7'd0};             nv = 1; end
            1:       begin plan = {7'd127, 7'd127, 7'd127, 7'd127};     nv = 2; end
            2:       begin plan = {7'd0, 7'd16, 7'd64, 7'd0};           nv = 8; end
            3:       begin plan = {7'd32, 7'd0, 7'd127, 7'd16};         nv = 3; end
            5:       begin plan = {7'd96, 7'd48, 7'd10, 7'd0};          nv = 8; end
            7:       begin plan = {ATTACK_RST, DECAY_RST, SUSTAIN_RST, RELEASE_RST};
                           nv = 5; end
            default: begin plan = cfg_t'($urandom);                     nv = 2 + ph / 2; end
        endcase
        set_register(REG_ATTACK, plan.attack_time);
        set_register(REG_DECAY, plan.decay_time);
        set_register(REG_SUSTAIN, plan.sustain_level);
        set_register(REG_RELEASE, plan.release_time);
        base = VOICE_W'($urandom_range(0, VOICES - 1));
        for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            r = $urandom_range(0, 99);
            v = base + VOICE_W'($urandom_range(0, nv - 1));
            if (r < 10) begin
                send_word(1'($urandom_range(0, 1)), VOICE_W'($urandom_range(0, VOICES - 1)),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else if (note_held[v]) begin
                if (r < 14) begin
                    send_word(OP_RELEASE, v, 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)));
                    note_held[v] = 1'b0;
                end else if (r < 17) begin
                    send_word(OP_TICK, v, 1'b1, 1'b1);
                end else begin
                    send_word(OP_TICK, v, 1'b0, 1'b1);
                end
            end else if ((phase_mem[v] == PH_IDLE) ? (r < 40) : (r < 13)) begin
                // note on; idle voices start notes more often so tails can finish
                send_word(OP_TICK, v, 1'($urandom_range(0, 1)), 1'b1);
                note_held[v] = 1'b1;
            end else begin
                send_word(OP_TICK, v, 1'b0, 1'b0);
            end
        end
    endtask

    initial begin
        for (int i = 0; i < VOICES; i++) begin
            phase_mem[i] = PH_IDLE;
            level_mem[i] = '0;
            note_held[i] = 1'b0;
        end
        attack_cfg  = ATTACK_RST;
        decay_cfg   = DECAY_RST;
        sustain_cfg = SUSTAIN_RST;
        release_cfg = RELEASE_RST;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_idle_voice();
        test_release_when_idle();
        test_attack_to_peak();
        test_decay_and_sustain();
        test_release_and_retrigger();
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
            test_random_traffic(ph);

        start <= 1'b0;
        while (expected_levels.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("PASS polyphonic_adsr_envelope_core");
        else
            $display("FAIL polyphonic_adsr_envelope_core");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("FAIL polyphonic_adsr_envelope_core");
        $finish;
    end

endmodule
